>>> sv/cnep_pkg.sv
`timescale 1ns / 1ps

package cnep_pkg;

    // Region tags; the parser phase uses the same codes.
    typedef enum logic [2:0] {
        REG_HEADER = 3'd0,
        REG_NAME   = 3'd1,
        REG_HPAD   = 3'd2,
        REG_DATA   = 3'd3,
        REG_DPAD   = 3'd4,
        REG_AFTER  = 3'd5
    } region_t;

    localparam logic [31:0] HEADER_BYTES = 32'd110;
    localparam logic [31:0] FSIZE_AT     = 32'd54;
    localparam logic [31:0] NSIZE_AT     = 32'd94;
    localparam logic [31:0] DIGITS       = 32'd8;
    localparam logic [3:0]  MARK_LEN     = 4'd10;

    // One ASCII hex digit; upper and lower case letters accepted, anything else is 0.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

    // Characters of the end-of-archive name, "TRAILER!!!".
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h54;
            4'd1:    ch = 8'h52;
            4'd2:    ch = 8'h41;
            4'd3:    ch = 8'h49;
            4'd4:    ch = 8'h4C;
            4'd5:    ch = 8'h45;
            4'd6:    ch = 8'h52;
            4'd7:    ch = 8'h21;
            4'd8:    ch = 8'h21;
            4'd9:    ch = 8'h21;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> sv/cpio_newc_entry_parser.sv
`timescale 1ns / 1ps
// An accepted request is registered in the output register and then shows on the master side.
// Throughput: one byte per cycle while the output register is free or drained; all parsing
// is a single combinational pass between the parser state registers and the output register.
// Reset: synchronous, active low; clears the phase, offset, size, match and trailer state
// and empties the output register.

module cpio_newc_entry_parser
    import cnep_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] archive_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] byte_out, [39:8] name_length, [71:40] file_length
    output logic [5:0]  m_tuser,   // [2:0] region, [3] entry_start, [4] sizes_valid,
                                   // [5] trailer_seen
    output logic        m_tlast    // entry_last
);

    // Parser state
    region_t     phase_reg,  phase_next;
    logic [31:0] off_reg,    off_next;
    logic [31:0] nsize_reg,  nsize_next;
    logic [31:0] fsize_reg,  fsize_next;
    logic [3:0]  tmc_reg,    tmc_next;
    logic        done_reg,   done_next;

    // Output register
    logic        m_valid_reg;
    logic [71:0] m_data_reg;
    logic [5:0]  m_user_reg;
    logic        m_last_reg;

    logic        accept;
    region_t     region;
    region_t     follow;
    logic        start, sizes_ok, last, matched;
    logic [31:0] sec_len;
    logic [32:0] off_inc;
    logic        sec_end;
    logic        name_nz, hpad_nz, data_nz, dpad_nz;
    logic [1:0]  hpad_len, dpad_len;
    logic [31:0] facc, nacc;

    // Take a new request whenever the output register is empty or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Section lengths. The header is 110 bytes, so the name pad is (2 - namesize) mod 4.
    assign hpad_len = 2'd2 - nsize_reg[1:0];
    assign dpad_len = 2'd0 - fsize_reg[1:0];
    assign name_nz  = (nsize_reg != 32'd0);
    assign hpad_nz  = (hpad_len != 2'd0);
    assign data_nz  = (fsize_reg != 32'd0);
    assign dpad_nz  = (dpad_len != 2'd0);

    always_comb begin
        unique case (phase_reg)
            REG_HEADER: sec_len = HEADER_BYTES;
            REG_NAME:   sec_len = nsize_reg;
            REG_HPAD:   sec_len = {30'd0, hpad_len};
            REG_DATA:   sec_len = fsize_reg;
            REG_DPAD:   sec_len = {30'd0, dpad_len};
            default:    sec_len = 32'd0;
        endcase
    end

    // Next nonempty section of this entry; header means the entry ends here.
    always_comb begin
        unique case (phase_reg)
            REG_HEADER: follow = name_nz ? REG_NAME : hpad_nz ? REG_HPAD :
                                 data_nz ? REG_DATA : dpad_nz ? REG_DPAD : REG_HEADER;
            REG_NAME:   follow = hpad_nz ? REG_HPAD : data_nz ? REG_DATA :
                                 dpad_nz ? REG_DPAD : REG_HEADER;
            REG_HPAD:   follow = data_nz ? REG_DATA : dpad_nz ? REG_DPAD : REG_HEADER;
            REG_DATA:   follow = dpad_nz ? REG_DPAD : REG_HEADER;
            default:    follow = REG_HEADER;
        endcase
    end

    assign off_inc = {1'b0, off_reg} + 33'd1;
    assign sec_end = (off_inc >= {1'b0, sec_len});

    // Each size field restarts at its first digit and shifts in one nibble per byte.
    assign facc = (off_reg == FSIZE_AT) ? 32'd0 : fsize_reg;
    assign nacc = (off_reg == NSIZE_AT) ? 32'd0 : nsize_reg;

    always_comb begin
        phase_next = phase_reg;
        off_next   = off_reg;
        nsize_next = nsize_reg;
        fsize_next = fsize_reg;
        tmc_next   = tmc_reg;
        done_next  = done_reg;
        region     = phase_reg;
        start      = 1'b0;
        sizes_ok   = 1'b0;
        last       = 1'b0;
        matched    = 1'b0;

        if (done_reg || phase_reg == REG_AFTER) begin
            // Past the trailer: tag everything as after trailer, hold the lengths.
            phase_next = REG_AFTER;
            done_next  = 1'b1;
            region     = REG_AFTER;
        end else begin
            if (phase_reg == REG_HEADER) begin
                if (off_reg == 32'd0) begin
                    start    = 1'b1;
                    tmc_next = 4'd0;
                end
                if (off_reg >= FSIZE_AT && off_reg < FSIZE_AT + DIGITS) begin
                    fsize_next = {facc[27:0], hex_value(s_tdata)};
                end
                if (off_reg >= NSIZE_AT && off_reg < NSIZE_AT + DIGITS) begin
                    nsize_next = {nacc[27:0], hex_value(s_tdata)};
                end
                if (off_reg == HEADER_BYTES - 32'd1) begin
                    sizes_ok = 1'b1;
                end
            end else if (phase_reg == REG_NAME) begin
                // Advance the match only while every earlier name byte has matched.
                if (off_reg < {28'd0, MARK_LEN} && {28'd0, tmc_reg} == off_reg &&
                    s_tdata == trailer_char(off_reg[3:0])) begin
                    tmc_next = tmc_reg + 4'd1;
                    matched  = (tmc_next == MARK_LEN);
                end
            end

            if (matched) begin
                done_next  = 1'b1;
                phase_next = REG_AFTER;
                off_next   = 32'd0;
            end else if (sec_end) begin
                last       = (follow == REG_HEADER);
                phase_next = follow;
                off_next   = 32'd0;
            end else begin
                off_next   = off_inc[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= REG_HEADER;
            off_reg     <= 32'd0;
            nsize_reg   <= 32'd0;
            fsize_reg   <= 32'd0;
            tmc_reg     <= 4'd0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                off_reg     <= off_next;
                nsize_reg   <= nsize_next;
                fsize_reg   <= fsize_next;
                tmc_reg     <= tmc_next;
                done_reg    <= done_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: load with each accepted request, hold otherwise.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {fsize_next, nsize_next, s_tdata};
            m_user_reg <= {done_next, sizes_ok, start, region};
            m_last_reg <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // Once the trailer is seen, only reset clears it.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("trailer flag dropped");

    // The match counter never passes the length of the trailer name.
    a_tmc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tmc_reg <= MARK_LEN)
        else $error("trailer match count out of range");

    // A byte accepted after the trailer comes out tagged as after trailer.
    a_after_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && done_reg) |=> (m_tuser[2:0] == REG_AFTER && m_tuser[5] && !m_tlast))
        else $error("byte after trailer mis-tagged");

    // The end-of-entry mark never lands on a header byte that is not the last one.
    a_last_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && m_tuser[2:0] == REG_HEADER) |-> m_tuser[4])
        else $error("entry end inside header");
`endif

endmodule
